// File: rtl/core/imrt_pkg.sv
// ----------------------------------------------------------------------------
// imrt_pkg
// Shared types and codes for the interval map range table core.
// ----------------------------------------------------------------------------
package imrt_pkg;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic OP_ASSIGN = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_EVAL  = 5'b00100,
        ST_TAIL  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    typedef struct packed {
        logic load;
        logic fetch;
        logic push_entry;
        logic push_begin;
        logic push_end;
        logic take_cur;
        logic adv;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_lookup;
        logic empty_range;
        logic at_end;
        logic key_lt_kb;
        logic key_le_kb;
        logic key_le_ke;
        logic pushed_begin;
        logic pushed_end;
        logic out_free;
    } stat_t;

endpackage

// File: rtl/core/imrt_ctrl.sv
// ----------------------------------------------------------------------------
// imrt_ctrl
// Sequencer: walks the table one entry at a time and picks the datapath step.
// ----------------------------------------------------------------------------
module imrt_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  imrt_pkg::stat_t stat,
    output imrt_pkg::cmd_t  cmd
);
    import imrt_pkg::*;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (!stat.is_lookup && stat.empty_range) begin
                    state_next = ST_DONE;
                end else if (stat.at_end) begin
                    state_next = stat.is_lookup ? ST_DONE : ST_TAIL;
                end else begin
                    cmd.fetch  = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (stat.is_lookup) begin
                    if (stat.key_le_kb) begin
                        cmd.take_cur = 1'b1;
                        cmd.adv      = 1'b1;
                        state_next   = ST_FETCH;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else if (stat.key_lt_kb) begin
                    cmd.push_entry = 1'b1;
                    cmd.take_cur   = 1'b1;
                    cmd.adv        = 1'b1;
                    state_next     = ST_FETCH;
                end else if (!stat.pushed_begin) begin
                    cmd.push_begin = 1'b1;
                end else if (stat.key_le_ke) begin
                    cmd.take_cur = 1'b1;
                    cmd.adv      = 1'b1;
                    state_next   = ST_FETCH;
                end else if (!stat.pushed_end) begin
                    cmd.push_end = 1'b1;
                end else begin
                    cmd.push_entry = 1'b1;
                    cmd.adv        = 1'b1;
                    state_next     = ST_FETCH;
                end
            end
            ST_TAIL: begin
                if (!stat.pushed_begin) begin
                    cmd.push_begin = 1'b1;
                end else if (!stat.pushed_end) begin
                    cmd.push_end = 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/imrt_dpath.sv
// ----------------------------------------------------------------------------
// imrt_dpath
// Ping-pong breakpoint tables, scan registers, rebuild counter and result.
// ----------------------------------------------------------------------------
module imrt_dpath #(
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_BITS    = 16,
    parameter int VALUE_BITS  = 8,
    parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [VALUE_BITS-1:0] cfg_wr_data,
    input  logic                  s_opcode,
    input  logic [KEY_BITS-1:0]   s_key_begin,
    input  logic [KEY_BITS-1:0]   s_key_end,
    input  logic [VALUE_BITS-1:0] s_new_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_read_value,
    output logic [1:0]            m_status,
    output logic [CNT_W-1:0]      m_entries_used,
    input  imrt_pkg::cmd_t        cmd,
    output imrt_pkg::stat_t       stat
);
    import imrt_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int NW    = $clog2(MAX_ENTRIES + 3);

    logic [KEY_BITS-1:0]   mem_key [2][MAX_ENTRIES];
    logic [VALUE_BITS-1:0] mem_val [2][MAX_ENTRIES];

    logic                  bank_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      i_reg;
    logic [NW-1:0]         n_reg;
    logic [VALUE_BITS-1:0] dflt_reg, last_reg, cur_reg, v_reg;
    logic [KEY_BITS-1:0]   kb_reg, ke_reg, rkey_reg;
    logic [VALUE_BITS-1:0] rval_reg;
    logic                  op_reg, pb_reg, pe_reg;
    logic                  push;
    logic [KEY_BITS-1:0]   pkey;
    logic [VALUE_BITS-1:0] pval;
    logic                  over, empty, commit;

    assign empty  = !(kb_reg < ke_reg);
    assign over   = n_reg > NW'(MAX_ENTRIES);
    assign commit = (op_reg == OP_ASSIGN) && !empty && !over;

    assign stat.is_lookup    = (op_reg == OP_LOOKUP);
    assign stat.empty_range  = empty;
    assign stat.at_end       = (i_reg == count_reg);
    assign stat.key_lt_kb    = rkey_reg < kb_reg;
    assign stat.key_le_kb    = rkey_reg <= kb_reg;
    assign stat.key_le_ke    = rkey_reg <= ke_reg;
    assign stat.pushed_begin = pb_reg;
    assign stat.pushed_end   = pe_reg;
    assign stat.out_free     = !m_valid || m_ready;

    assign push = cmd.push_entry || cmd.push_begin || cmd.push_end;

    always_comb begin
        pkey = rkey_reg;
        pval = rval_reg;
        if (cmd.push_begin) begin
            pkey = kb_reg;
            pval = v_reg;
        end else if (cmd.push_end) begin
            pkey = ke_reg;
            pval = cur_reg;
        end
    end

    // table memory: read the live bank, build into the other one
    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            rkey_reg <= mem_key[bank_reg][i_reg[IDX_W-1:0]];
            rval_reg <= mem_val[bank_reg][i_reg[IDX_W-1:0]];
        end
        if (push && (pval != last_reg) && (n_reg < NW'(MAX_ENTRIES))) begin
            mem_key[~bank_reg][n_reg[IDX_W-1:0]] <= pkey;
            mem_val[~bank_reg][n_reg[IDX_W-1:0]] <= pval;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_opcode;
            kb_reg   <= s_key_begin;
            ke_reg   <= s_key_end;
            v_reg    <= s_new_value;
            i_reg    <= '0;
            n_reg    <= '0;
            last_reg <= dflt_reg;
            cur_reg  <= dflt_reg;
            pb_reg   <= 1'b0;
            pe_reg   <= 1'b0;
        end else begin
            if (cmd.adv) begin
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.take_cur) begin
                cur_reg <= rval_reg;
            end
            if (cmd.push_begin) begin
                pb_reg <= 1'b1;
            end
            if (cmd.push_end) begin
                pe_reg <= 1'b1;
            end
            // drop a breakpoint that repeats the value in force
            if (push && (pval != last_reg)) begin
                n_reg    <= n_reg + 1'b1;
                last_reg <= pval;
            end
        end
        if (cmd.out_load) begin
            m_read_value <= stat.is_lookup ? cur_reg : '0;
            if (stat.is_lookup) begin
                m_status <= STATUS_DONE;
            end else if (empty) begin
                m_status <= STATUS_EMPTY;
            end else if (over) begin
                m_status <= STATUS_FULL;
            end else begin
                m_status <= STATUS_DONE;
            end
            m_entries_used <= commit ? CNT_W'(n_reg) : count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg  <= 1'b0;
            count_reg <= '0;
            dflt_reg  <= '0;
            m_valid   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                dflt_reg <= cfg_wr_data;
            end
            if (cmd.out_load && commit) begin
                bank_reg  <= ~bank_reg;
                count_reg <= CNT_W'(n_reg);
            end
            if (cmd.out_load) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/core/interval_map_range_table_core.sv
// Accept to result: a lookup fetches and evaluates entries up to the first
// breakpoint above the key or the table end; an assign fetches and evaluates
// every stored entry on the single table read port, inserts the begin and end
// breakpoints, then passes tail and done; an empty range goes straight to
// done. One item in flight; the next is taken once the result loads and the
// block is idle again. Sync reset (aresetn low) empties table, default = zero.
// ----------------------------------------------------------------------------
// interval_map_range_table_core
// Sorted breakpoint table with range assign and point lookup.
// ----------------------------------------------------------------------------
module interval_map_range_table_core #(
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_BITS    = 16,
    parameter int VALUE_BITS  = 8,
    parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [VALUE_BITS-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_opcode,
    input  logic [KEY_BITS-1:0]   s_key_begin,
    input  logic [KEY_BITS-1:0]   s_key_end,
    input  logic [VALUE_BITS-1:0] s_new_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_read_value,
    output logic [1:0]            m_status,
    output logic [CNT_W-1:0]      m_entries_used
);
    import imrt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer: one table entry per fetch/evaluate pair
    imrt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // tables, rebuild logic and output register
    imrt_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS),
        .CNT_W       (CNT_W)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_opcode       (s_opcode),
        .s_key_begin    (s_key_begin),
        .s_key_end      (s_key_end),
        .s_new_value    (s_new_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_value   (m_read_value),
        .m_status       (m_status),
        .m_entries_used (m_entries_used),
        .cmd            (cmd),
        .stat           (stat)
    );

`ifndef SYNTHESIS
    // a committed table never exceeds its capacity
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_entries_used <= CNT_W'(MAX_ENTRIES)))
        else $error("entries_used above capacity");

    // an accepted item makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while busy");

    // a result is loaded only into a free output register
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result overwrote pending item");
`endif

endmodule
